// ===== hdl/biq_pkg.sv =====
// Shared types, widths and constants for the biquad high-pass filter.
package biq_pkg;

   localparam int COEF_WIDTH      = 32;
   localparam int DELAY_WIDTH     = 48;
   localparam int HALF_WIDTH      = 24;
   localparam int MUL_A_WIDTH     = COEF_WIDTH + 1;
   localparam int MUL_B_WIDTH     = HALF_WIDTH + 1;
   localparam int PROD_WIDTH      = MUL_A_WIDTH + MUL_B_WIDTH;
   localparam int PART_WIDTH      = COEF_WIDTH + HALF_WIDTH;
   localparam int FRAC_WIDTH      = PART_WIDTH + HALF_WIDTH + 1;
   localparam int SUM_WIDTH       = 60;
   localparam int CSR_INDEX_WIDTH = 3;

   // Reset coefficients of the DC-removing high-pass, in Q4.28.
   localparam longint RESET_B0_Q28 = 64'sd267898585;
   localparam longint RESET_B1_Q28 = -64'sd535797170;
   localparam longint RESET_B2_Q28 = 64'sd267898585;
   localparam longint RESET_A1_Q28 = -64'sd535794486;
   localparam longint RESET_A2_Q28 = 64'sd267361714;

   localparam logic signed [SUM_WIDTH-1:0] SAT_HI = SUM_WIDTH'(64'sh7FFF_FFFF_FFFF);
   localparam logic signed [SUM_WIDTH-1:0] SAT_LO = SUM_WIDTH'(-64'sh8000_0000_0000);

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_COEF_B0       = 3'd0,
      REG_COEF_B1       = 3'd1,
      REG_COEF_B2       = 3'd2,
      REG_COEF_A1       = 3'd3,
      REG_COEF_A2       = 3'd4,
      REG_FILTER_ENABLE = 3'd5
   } csr_reg_type;

   typedef struct packed {
      logic signed [COEF_WIDTH-1:0] b0;
      logic signed [COEF_WIDTH-1:0] b1;
      logic signed [COEF_WIDTH-1:0] b2;
      logic signed [COEF_WIDTH-1:0] a1;
      logic signed [COEF_WIDTH-1:0] a2;
      logic                         enable;
   } coef_type;

   typedef enum logic [2:0] {
      MUL_B0,
      MUL_B1,
      MUL_B2,
      MUL_A1_LO,
      MUL_A1_HI,
      MUL_A2_LO,
      MUL_A2_HI
   } mul_sel_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_B0,
      S_B1,
      S_B2,
      S_A1L,
      S_A1H,
      S_A2L,
      S_A2H,
      S_FR2,
      S_OUT
   } seq_state_type;

   typedef struct packed {
      mul_sel_type mul_sel;
      logic        accept;
      logic        ld_y;
      logic        ld_acc1;
      logic        ld_acc2;
      logic        ld_lo;
      logic        ld_mf;
      logic        sel_a2;
      logic        ld_d1;
      logic        ld_d2;
      logic        ld_out;
      logic        bypass;
   } ctrl_type;

   // Saturate a wide sum to the signed 48-bit accumulator range.
   function automatic logic signed [DELAY_WIDTH-1:0] sat_delay(
      input logic signed [SUM_WIDTH-1:0] v);
      logic signed [DELAY_WIDTH-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[DELAY_WIDTH-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[DELAY_WIDTH-1:0];
      end else begin
         r = v[DELAY_WIDTH-1:0];
      end
      return r;
   endfunction

endpackage

// ===== hdl/biq_mul.sv =====
// Shared signed multiplier with a registered product.
module biq_mul import biq_pkg::*; (
   input  logic                          clock,
   input  logic signed [MUL_A_WIDTH-1:0] op_a,
   input  logic signed [MUL_B_WIDTH-1:0] op_b,
   output logic signed [PROD_WIDTH-1:0]  prod
);

   logic signed [PROD_WIDTH-1:0] prod_ff;
   logic signed [PROD_WIDTH-1:0] prod_in;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ===== hdl/biq_coef.sv =====
// Coefficient and enable registers written through the CSR port.
module biq_coef import biq_pkg::*; #(
   parameter int COEF_FRAC_BITS = 28
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [COEF_WIDTH-1:0]      csr_wdata,
   output coef_type                   coef
);

   // Reset values are scaled from Q4.28, rounding half up when bits are dropped.
   function automatic longint scale_q28(input longint v);
      longint r;
      if (COEF_FRAC_BITS >= 28) begin
         r = v <<< (COEF_FRAC_BITS - 28);
      end else begin
         r = (v + (longint'(1) <<< (27 - COEF_FRAC_BITS))) >>> (28 - COEF_FRAC_BITS);
      end
      return r;
   endfunction

   localparam coef_type COEF_RESET = '{
      b0:     COEF_WIDTH'(scale_q28(RESET_B0_Q28)),
      b1:     COEF_WIDTH'(scale_q28(RESET_B1_Q28)),
      b2:     COEF_WIDTH'(scale_q28(RESET_B2_Q28)),
      a1:     COEF_WIDTH'(scale_q28(RESET_A1_Q28)),
      a2:     COEF_WIDTH'(scale_q28(RESET_A2_Q28)),
      enable: 1'b1
   };

   coef_type coef_ff;
   coef_type coef_in;

   always_comb begin
      coef_in = coef_ff;
      if (csr_wr_en) begin
         case (csr_reg_type'(csr_index))
            REG_COEF_B0:       coef_in.b0 = signed'(csr_wdata);
            REG_COEF_B1:       coef_in.b1 = signed'(csr_wdata);
            REG_COEF_B2:       coef_in.b2 = signed'(csr_wdata);
            REG_COEF_A1:       coef_in.a1 = signed'(csr_wdata);
            REG_COEF_A2:       coef_in.a2 = signed'(csr_wdata);
            REG_FILTER_ENABLE: coef_in.enable = csr_wdata[0];
            default:           coef_in = coef_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= COEF_RESET;
      end else begin
         coef_ff <= coef_in;
      end
   end

   assign coef = coef_ff;

endmodule

// ===== hdl/biq_seq.sv =====
// Sequencer that steps one sample through the shared multiplier.
module biq_seq import biq_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   input  logic     enable,
   input  logic     out_free,
   output logic     req_tready,
   output ctrl_type ctrl
);

   seq_state_type state_ff;
   seq_state_type state_in;
   logic          bypass_ff;
   logic          bypass_in;

   always_comb begin
      state_in     = state_ff;
      bypass_in    = bypass_ff;
      req_tready   = 1'b0;
      ctrl         = '0;
      ctrl.mul_sel = MUL_B0;
      ctrl.bypass  = bypass_ff;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ctrl.accept = 1'b1;
               bypass_in   = ~enable;
               state_in    = enable ? S_B0 : S_OUT;
            end
         end
         S_B0: begin
            ctrl.mul_sel = MUL_B0;
            state_in     = S_B1;
         end
         S_B1: begin
            ctrl.mul_sel = MUL_B1;
            ctrl.ld_y    = 1'b1;
            state_in     = S_B2;
         end
         S_B2: begin
            ctrl.mul_sel = MUL_B2;
            ctrl.ld_acc1 = 1'b1;
            state_in     = S_A1L;
         end
         S_A1L: begin
            ctrl.mul_sel = MUL_A1_LO;
            ctrl.ld_acc2 = 1'b1;
            state_in     = S_A1H;
         end
         S_A1H: begin
            ctrl.mul_sel = MUL_A1_HI;
            ctrl.ld_lo   = 1'b1;
            state_in     = S_A2L;
         end
         S_A2L: begin
            ctrl.mul_sel = MUL_A2_LO;
            ctrl.ld_mf   = 1'b1;
            state_in     = S_A2H;
         end
         S_A2H: begin
            ctrl.mul_sel = MUL_A2_HI;
            ctrl.ld_lo   = 1'b1;
            ctrl.ld_d1   = 1'b1;
            state_in     = S_FR2;
         end
         S_FR2: begin
            ctrl.ld_mf  = 1'b1;
            ctrl.sel_a2 = 1'b1;
            state_in    = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               ctrl.ld_out = 1'b1;
               ctrl.ld_d2  = ~bypass_ff;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         bypass_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         bypass_ff <= bypass_in;
      end
   end

endmodule

// ===== hdl/biquad_highpass_filter.sv =====
// Top level of the transposed direct form II biquad with one shared multiplier.
// Each sample steps through seven products in the one multiplier, a rounding state for the last
// feedback term, the output state and the accept state; a new sample is taken only after the
// result is loaded into the output register, and the output state waits while a pending result
// is not yet taken. When disabled, a sample goes from the accept state straight to the output state.
// Reset is synchronous and active high; it clears both delays and restores the coefficients.
module biquad_highpass_filter import biq_pkg::*; #(
   parameter int SAMPLE_WIDTH   = 16,
   parameter int COEF_FRAC_BITS = 28,
   localparam int TDATA_WIDTH   = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [TDATA_WIDTH-1:0]     req_tdata,   // sample_in
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [TDATA_WIDTH-1:0]     rsp_tdata,   // sample_out
   output logic                       rsp_tuser,   // clipped
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [COEF_WIDTH-1:0]      csr_wdata
);

   localparam int RND_WIDTH = DELAY_WIDTH + 1;
   localparam logic signed [RND_WIDTH-1:0] OUT_RND = RND_WIDTH'(64'sd1 <<< (COEF_FRAC_BITS - 1));
   localparam logic signed [RND_WIDTH-1:0] S_MAX =
      RND_WIDTH'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
   localparam logic signed [RND_WIDTH-1:0] S_MIN = RND_WIDTH'(-(64'sd1 <<< (SAMPLE_WIDTH - 1)));
   localparam logic [FRAC_WIDTH-1:0] FRAC_RND = FRAC_WIDTH'(1) << (COEF_FRAC_BITS - 1);
   localparam logic [DELAY_WIDTH-1:0] MAG_CAP = DELAY_WIDTH'(1) << (DELAY_WIDTH - 1);
   localparam logic [DELAY_WIDTH-1:0] MAG_MAX = MAG_CAP - DELAY_WIDTH'(1);

   coef_type coef;
   ctrl_type ctrl;
   logic     out_free;

   logic signed [MUL_A_WIDTH-1:0]  op_a;
   logic signed [MUL_B_WIDTH-1:0]  op_b;
   logic signed [PROD_WIDTH-1:0]   prod;
   logic [COEF_WIDTH-1:0]          mag_a1;
   logic [COEF_WIDTH-1:0]          mag_a2;

   logic signed [SAMPLE_WIDTH-1:0] x_ff,    x_in;
   logic signed [DELAY_WIDTH-1:0]  y_ff,    y_in;
   logic [DELAY_WIDTH-1:0]         ma_ff,   ma_in;
   logic signed [SUM_WIDTH-1:0]    acc1_ff, acc1_in;
   logic signed [SUM_WIDTH-1:0]    acc2_ff, acc2_in;
   logic [PART_WIDTH-1:0]          lo_ff,   lo_in;
   logic signed [DELAY_WIDTH-1:0]  mf_ff,   mf_in;
   logic signed [DELAY_WIDTH-1:0]  d1_ff,   d1_in;
   logic signed [DELAY_WIDTH-1:0]  d2_ff,   d2_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_sample_ff, rsp_sample_in;
   logic                           rsp_clip_ff,   rsp_clip_in;

   logic [FRAC_WIDTH-1:0]          frac_sum;
   logic [FRAC_WIDTH-1:0]          frac_q;
   logic                           frac_big;
   logic                           frac_neg;
   logic [DELAY_WIDTH-1:0]         frac_mag;
   logic signed [RND_WIDTH-1:0]    y_rnd;
   logic signed [RND_WIDTH-1:0]    y_int;
   logic signed [SAMPLE_WIDTH-1:0] y_sample;
   logic                           y_clip;

   biq_coef #(
      .COEF_FRAC_BITS(COEF_FRAC_BITS)
   ) u_coef (
      .clock    (clock),
      .reset    (reset),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .coef     (coef)
   );

   assign out_free = ~rsp_valid_ff | rsp_tready;

   biq_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .enable    (coef.enable),
      .out_free  (out_free),
      .req_tready(req_tready),
      .ctrl      (ctrl)
   );

   // Feedback products are formed on magnitudes, 24 bits of |y| at a time.
   assign mag_a1 = coef.a1[COEF_WIDTH-1] ? unsigned'(-coef.a1) : unsigned'(coef.a1);
   assign mag_a2 = coef.a2[COEF_WIDTH-1] ? unsigned'(-coef.a2) : unsigned'(coef.a2);

   always_comb begin
      case (ctrl.mul_sel)
         MUL_B0: begin
            op_a = MUL_A_WIDTH'(coef.b0);
            op_b = MUL_B_WIDTH'(x_ff);
         end
         MUL_B1: begin
            op_a = MUL_A_WIDTH'(coef.b1);
            op_b = MUL_B_WIDTH'(x_ff);
         end
         MUL_B2: begin
            op_a = MUL_A_WIDTH'(coef.b2);
            op_b = MUL_B_WIDTH'(x_ff);
         end
         MUL_A1_LO: begin
            op_a = signed'({1'b0, mag_a1});
            op_b = signed'({1'b0, ma_ff[HALF_WIDTH-1:0]});
         end
         MUL_A1_HI: begin
            op_a = signed'({1'b0, mag_a1});
            op_b = signed'({1'b0, ma_ff[DELAY_WIDTH-1:HALF_WIDTH]});
         end
         MUL_A2_LO: begin
            op_a = signed'({1'b0, mag_a2});
            op_b = signed'({1'b0, ma_ff[HALF_WIDTH-1:0]});
         end
         MUL_A2_HI: begin
            op_a = signed'({1'b0, mag_a2});
            op_b = signed'({1'b0, ma_ff[DELAY_WIDTH-1:HALF_WIDTH]});
         end
         default: begin
            op_a = MUL_A_WIDTH'(coef.b0);
            op_b = MUL_B_WIDTH'(x_ff);
         end
      endcase
   end

   biq_mul u_mul (
      .clock(clock),
      .op_a (op_a),
      .op_b (op_b),
      .prod (prod)
   );

   // Join the partial products, round half up, cap at 2^47 (2^47-1 if positive), restore the sign.
   always_comb begin
      frac_sum = FRAC_WIDTH'({prod[PART_WIDTH-1:0], {HALF_WIDTH{1'b0}}})
               + FRAC_WIDTH'(lo_ff) + FRAC_RND;
      frac_q   = frac_sum >> COEF_FRAC_BITS;
      frac_big = |frac_q[FRAC_WIDTH-1:DELAY_WIDTH-1];
      frac_neg = (ctrl.sel_a2 ? coef.a2[COEF_WIDTH-1] : coef.a1[COEF_WIDTH-1])
               ^ y_ff[DELAY_WIDTH-1];
      if (frac_neg) begin
         frac_mag = frac_big ? MAG_CAP : frac_q[DELAY_WIDTH-1:0];
         mf_in    = signed'(DELAY_WIDTH'(0) - frac_mag);
      end else begin
         frac_mag = frac_big ? MAG_MAX : frac_q[DELAY_WIDTH-1:0];
         mf_in    = signed'(frac_mag);
      end
   end

   // Output rounding toward plus infinity on ties, then saturation to the sample range.
   always_comb begin
      y_rnd = RND_WIDTH'(y_ff) + OUT_RND;
      y_int = y_rnd >>> COEF_FRAC_BITS;
      if (y_int > S_MAX) begin
         y_sample = S_MAX[SAMPLE_WIDTH-1:0];
         y_clip   = 1'b1;
      end else if (y_int < S_MIN) begin
         y_sample = S_MIN[SAMPLE_WIDTH-1:0];
         y_clip   = 1'b1;
      end else begin
         y_sample = y_int[SAMPLE_WIDTH-1:0];
         y_clip   = 1'b0;
      end
   end

   always_comb begin
      x_in          = ctrl.accept ? signed'(req_tdata[SAMPLE_WIDTH-1:0]) : x_ff;
      y_in          = ctrl.ld_y ? sat_delay(SUM_WIDTH'(prod) + SUM_WIDTH'(d1_ff)) : y_ff;
      ma_in         = ctrl.ld_acc1 ? (y_ff[DELAY_WIDTH-1] ? unsigned'(-y_ff) : unsigned'(y_ff))
                                   : ma_ff;
      acc1_in       = ctrl.ld_acc1 ? SUM_WIDTH'(prod) + SUM_WIDTH'(d2_ff) : acc1_ff;
      acc2_in       = ctrl.ld_acc2 ? SUM_WIDTH'(prod) : acc2_ff;
      lo_in         = ctrl.ld_lo ? prod[PART_WIDTH-1:0] : lo_ff;
      d1_in         = ctrl.ld_d1 ? sat_delay(acc1_ff - SUM_WIDTH'(mf_ff)) : d1_ff;
      d2_in         = ctrl.ld_d2 ? sat_delay(acc2_ff - SUM_WIDTH'(mf_ff)) : d2_ff;
      rsp_valid_in  = ctrl.ld_out | (rsp_valid_ff & ~rsp_tready);
      rsp_sample_in = rsp_sample_ff;
      rsp_clip_in   = rsp_clip_ff;
      if (ctrl.ld_out) begin
         rsp_sample_in = ctrl.bypass ? x_ff : y_sample;
         rsp_clip_in   = ~ctrl.bypass & y_clip;
      end
   end

   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      y_ff          <= y_in;
      ma_ff         <= ma_in;
      acc1_ff       <= acc1_in;
      acc2_ff       <= acc2_in;
      lo_ff         <= lo_in;
      mf_ff         <= ctrl.ld_mf ? mf_in : mf_ff;
      rsp_sample_ff <= rsp_sample_in;
      rsp_clip_ff   <= rsp_clip_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_ff        <= '0;
         d2_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         d1_ff        <= d1_in;
         d2_ff        <= d2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_WIDTH'(unsigned'(rsp_sample_ff));
   assign rsp_tuser  = rsp_clip_ff;

`ifndef NO_ASSERTIONS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("block ready again right after taking a sample");

   a_bypass_holds_state: assert property (@(posedge clock) disable iff (reset)
      (ctrl.ld_out && ctrl.bypass) |=> ($stable(d1_ff) && $stable(d2_ff)))
      else $error("filter state changed on a pass-through sample");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !ctrl.ld_out)
      else $error("pending result overwritten");

   a_clip_at_rail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_clip_ff) |->
      (rsp_sample_ff == S_MAX[SAMPLE_WIDTH-1:0] || rsp_sample_ff == S_MIN[SAMPLE_WIDTH-1:0]))
      else $error("clip flag set on a sample that is not at a rail");
`endif

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the biquad high-pass filter: directed and random samples.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import biq_pkg::*;

   localparam int          SAMPLE_BITS    = 16;
   localparam int          FRAC_BITS      = 28;
   localparam int          WATCHDOG_LIMIT = 2000;
   localparam int          HOLD_CYCLES    = 400;
   localparam int          DRAIN_CYCLES   = 20;
   localparam longint      ACC_MAX        = 64'sh7FFF_FFFF_FFFF;
   localparam longint      ACC_MIN        = -64'sh8000_0000_0000;
   localparam longint      SAMPLE_MAX     = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
   localparam longint      SAMPLE_MIN     = -(64'sd1 <<< (SAMPLE_BITS - 1));
   localparam logic [2:0]  CSR_SPARE_LOW  = 3'd6;
   localparam logic [2:0]  CSR_SPARE_HIGH = 3'd7;

   typedef struct {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          clipped;
   } filter_result_type;

   typedef struct {
      logic [CSR_INDEX_WIDTH-1:0] index;
      logic [COEF_WIDTH-1:0]      value;
   } csr_write_type;

   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [SAMPLE_BITS-1:0]     req_tdata  = '0;   // sample_in
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [SAMPLE_BITS-1:0]     rsp_tdata;         // sample_out
   logic                       rsp_tuser;         // clipped
   logic                       csr_wr_en  = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index  = '0;
   logic [COEF_WIDTH-1:0]      csr_wdata  = '0;

   // Filter model state and its copy of the registers.
   longint coef_b0 = RESET_B0_Q28;
   longint coef_b1 = RESET_B1_Q28;
   longint coef_b2 = RESET_B2_Q28;
   longint coef_a1 = RESET_A1_Q28;
   longint coef_a2 = RESET_A2_Q28;
   logic   filter_on = 1'b1;
   longint delay_first = 0;
   longint delay_second = 0;

   filter_result_type             expected_results[$];
   csr_write_type                 pending_writes[$];
   logic signed [SAMPLE_BITS-1:0] last_sample = '0;

   int sender_idle_pct   = 0;
   int receiver_idle_pct = 0;
   int stall_requests    = 0;
   int stall_served      = 0;
   int hold_left         = 0;
   int idle_cycles       = 0;
   int failures          = 0;
   int samples_sent      = 0;
   int bypassed_samples  = 0;
   int results_checked   = 0;
   int clipped_results   = 0;
   int settings_loaded   = 0;

   biquad_highpass_filter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic longint sat_acc(input longint v);
      if (v > ACC_MAX) begin
         return ACC_MAX;
      end
      if (v < ACC_MIN) begin
         return ACC_MIN;
      end
      return v;
   endfunction

   // Feedback term: the magnitude is rounded half up, so rounding is symmetric about zero.
   function automatic longint feedback_term(input longint coef, input longint acc);
      logic [127:0] mag_coef;
      logic [127:0] mag_acc;
      logic [127:0] mag;
      longint       q;
      mag_coef = 128'(coef < 0 ? -coef : coef);
      mag_acc  = 128'(acc < 0 ? -acc : acc);
      mag = (mag_coef * mag_acc + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      if (mag > (128'd1 << 47)) begin
         mag = 128'd1 << 47;
      end
      q = longint'(mag[63:0]);
      if ((coef < 0) != (acc < 0)) begin
         q = -q;
      end
      return sat_acc(q);
   endfunction

   function automatic filter_result_type filter_sample(
      input logic signed [SAMPLE_BITS-1:0] sample_in);
      filter_result_type r;
      longint            x;
      longint            acc;
      longint            next_first;
      longint            next_second;
      longint            y;
      x = sample_in;
      r.clipped = 1'b0;
      if (!filter_on) begin
         r.sample = sample_in;
         return r;
      end
      acc = sat_acc(coef_b0 * x + delay_first);
      next_first  = sat_acc(coef_b1 * x + delay_second - feedback_term(coef_a1, acc));
      next_second = sat_acc(coef_b2 * x - feedback_term(coef_a2, acc));
      delay_first  = next_first;
      delay_second = next_second;
      y = (acc + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (y > SAMPLE_MAX) begin
         y = SAMPLE_MAX;
         r.clipped = 1'b1;
      end else if (y < SAMPLE_MIN) begin
         y = SAMPLE_MIN;
         r.clipped = 1'b1;
      end
      r.sample = SAMPLE_BITS'(y);
      return r;
   endfunction

   function automatic void apply_register(input logic [CSR_INDEX_WIDTH-1:0] index,
                                          input logic [COEF_WIDTH-1:0] value);
      case (index)
         REG_COEF_B0:       coef_b0 = longint'($signed(value));
         REG_COEF_B1:       coef_b1 = longint'($signed(value));
         REG_COEF_B2:       coef_b2 = longint'($signed(value));
         REG_COEF_A1:       coef_a1 = longint'($signed(value));
         REG_COEF_A2:       coef_a2 = longint'($signed(value));
         REG_FILTER_ENABLE: filter_on = value[0];
         default: ;
      endcase
   endfunction

   function automatic void stage_write(input logic [CSR_INDEX_WIDTH-1:0] index,
                                       input logic [COEF_WIDTH-1:0] value);
      csr_write_type w;
      w.index = index;
      w.value = value;
      pending_writes.push_back(w);
   endfunction

   function automatic logic [COEF_WIDTH-1:0] to_coef_word(input real v);
      real c;
      c = v;
      if (c > 7.99) begin
         c = 7.99;
      end else if (c < -8.0) begin
         c = -8.0;
      end
      return COEF_WIDTH'($rtoi(c * real'(64'd1 << FRAC_BITS)));
   endfunction

   function automatic logic [COEF_WIDTH-1:0] extreme_coef();
      case ($urandom_range(5))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         3:       return 32'h0000_0001;
         4:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic real unit_random(input int span);
      return real'(int'($urandom_range(2 * span)) - span) / 1000.0;
   endfunction

   // Most settings are stable filters so that the delays carry real history.
   function automatic void choose_random_setting();
      real                   r;
      real                   th;
      real                   k;
      logic [COEF_WIDTH-1:0] enable_word;
      enable_word = $urandom | 32'd1;
      case ($urandom_range(9))
         0, 1, 2, 3: begin
            r = 0.9 + $urandom_range(999) / 10000.0;
            k = (1.0 + r) / 2.0;
            stage_write(REG_COEF_B0, to_coef_word(k));
            stage_write(REG_COEF_B1, to_coef_word(-2.0 * k));
            stage_write(REG_COEF_B2, to_coef_word(k));
            stage_write(REG_COEF_A1, to_coef_word(-2.0 * r));
            stage_write(REG_COEF_A2, to_coef_word(r * r));
         end
         4, 5: begin
            r  = $urandom_range(990) / 1000.0;
            th = $urandom_range(3141) / 1000.0;
            stage_write(REG_COEF_B0, to_coef_word(unit_random(2000)));
            stage_write(REG_COEF_B1, to_coef_word(unit_random(2000)));
            stage_write(REG_COEF_B2, to_coef_word(unit_random(2000)));
            stage_write(REG_COEF_A1, to_coef_word(-2.0 * r * $cos(th)));
            stage_write(REG_COEF_A2, to_coef_word(r * r));
         end
         6: begin
            stage_write(REG_COEF_B0, $urandom);
            stage_write(REG_COEF_B1, $urandom);
            stage_write(REG_COEF_B2, $urandom);
            stage_write(REG_COEF_A1, $urandom);
            stage_write(REG_COEF_A2, $urandom);
         end
         7: begin
            stage_write(REG_COEF_B0, extreme_coef());
            stage_write(REG_COEF_B1, extreme_coef());
            stage_write(REG_COEF_B2, extreme_coef());
            stage_write(REG_COEF_A1, extreme_coef());
            stage_write(REG_COEF_A2, extreme_coef());
         end
         8: begin
            stage_write(REG_COEF_B0, $urandom);
            stage_write(REG_COEF_A1, $urandom);
            enable_word = $urandom & ~32'd1;
         end
         default: ;
      endcase
      if ($urandom_range(3) == 0) begin
         stage_write($urandom_range(1) ? CSR_SPARE_LOW : CSR_SPARE_HIGH, $urandom);
      end
      stage_write(REG_FILTER_ENABLE, enable_word);
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(9))
         0, 1, 2, 3, 4, 5: return SAMPLE_BITS'($urandom);
         6, 7:             return SAMPLE_BITS'(int'($urandom_range(2000)) - 1000);
         8:                return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
         default:          return last_sample;
      endcase
   endfunction

   // Called at a rising edge; the block must be idle.
   task automatic commit_writes();
      csr_write_type w;
      while (pending_writes.size() > 0) begin
         w = pending_writes.pop_front();
         csr_wr_en <= 1'b1;
         csr_index <= w.index;
         csr_wdata <= w.value;
         apply_register(w.index, w.value);
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      settings_loaded++;
   endtask

   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      expected_results.push_back(filter_sample(value));
      if (!filter_on) begin
         bypassed_samples++;
      end
      samples_sent++;
      last_sample = value;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() > 0) begin
         @(posedge clock);
      end
   endtask

   task automatic test_high_pass_defaults();
      send_sample(16'sh7FFF);
      send_sample(16'sh7FFF);
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      send_sample(16'sh0000);
      send_sample(16'sh0001);
      send_sample(-16'sh0001);
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      send_sample(16'sh7FFF);
      drain_results();
   endtask

   // A gain of one half makes odd samples land exactly between two outputs.
   task automatic test_rounding_ties();
      stage_write(REG_COEF_B0, 32'h0800_0000);
      stage_write(REG_COEF_B1, 32'h0);
      stage_write(REG_COEF_B2, 32'h0);
      stage_write(REG_COEF_A1, 32'h0);
      stage_write(REG_COEF_A2, 32'h0);
      commit_writes();
      send_sample(16'sh0000);
      send_sample(16'sh0000);
      send_sample(16'sh0003);
      send_sample(-16'sh0003);
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      drain_results();
   endtask

   // Upper bits of the enable word and writes to unused indexes must have no effect.
   task automatic test_bypass_mode();
      stage_write(REG_FILTER_ENABLE, 32'hFFFF_FFFE);
      stage_write(CSR_SPARE_LOW, 32'hFFFF_FFFF);
      stage_write(CSR_SPARE_HIGH, 32'hA5A5_5A5A);
      commit_writes();
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      send_sample(-16'sh0001);
      drain_results();
      stage_write(REG_FILTER_ENABLE, 32'h0000_0001);
      commit_writes();
   endtask

   task automatic test_saturation_extremes();
      drain_results();
      stage_write(REG_COEF_B0, 32'h7FFF_FFFF);
      stage_write(REG_COEF_B1, 32'h7FFF_FFFF);
      stage_write(REG_COEF_B2, 32'h8000_0000);
      stage_write(REG_COEF_A1, 32'h8000_0000);
      stage_write(REG_COEF_A2, 32'h7FFF_FFFF);
      commit_writes();
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      send_sample(16'sh0000);
      drain_results();
   endtask

   task automatic test_random_filtering(input int item_count);
      int remaining;
      int burst;
      remaining = item_count;
      while (remaining > 0) begin
         drain_results();
         choose_random_setting();
         commit_writes();
         burst = $urandom_range(90, 30);
         if (burst > remaining) begin
            burst = remaining;
         end
         repeat (burst) send_sample(pick_sample());
         remaining -= burst;
      end
      drain_results();
   endtask

   // The receiver stops for a long stretch while samples keep coming, so the input stalls.
   task automatic test_output_backpressure(input int item_count);
      stall_requests++;
      repeat (item_count) send_sample(pick_sample());
      drain_results();
   endtask

   task automatic test_input_pause(input int item_count);
      repeat (item_count) send_sample(pick_sample());
      drain_results();
      repeat (item_count) send_sample(pick_sample());
      drain_results();
   endtask

   always @(posedge clock) begin
      if (stall_served != stall_requests) begin
         stall_served = stall_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // Both sides are stable at the falling edge, so a transaction seen here
   // completes at the next rising edge.
   always @(negedge clock) begin : check_results
      filter_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result transaction: sample_out %0d", $signed(rsp_tdata));
            failures++;
         end else begin
            want = expected_results.pop_front();
            results_checked++;
            if (want.clipped) begin
               clipped_results++;
            end
            if (rsp_tdata !== want.sample) begin
               $error("sample_out: expected %0d, actual %0d", want.sample,
                      $signed(rsp_tdata));
               failures++;
            end
            if (rsp_tuser !== want.clipped) begin
               $error("clipped: expected %0d, actual %0d", want.clipped, rsp_tuser);
               failures++;
            end
         end
      end
   end

   always @(negedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $error("no transaction for %0d cycles, %0d results outstanding",
                idle_cycles, expected_results.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      sender_idle_pct   = 11;
      receiver_idle_pct = 64;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_high_pass_defaults();
      test_rounding_ties();
      test_bypass_mode();
      test_saturation_extremes();
      test_random_filtering(600);
      test_output_backpressure(60);

      sender_idle_pct   = 64;
      receiver_idle_pct = 11;
      test_random_filtering(600);
      test_input_pause(20);

      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      test_random_filtering(600);
      test_output_backpressure(60);

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_results.size() != 0) begin
         $error("%0d expected results never arrived", expected_results.size());
         failures++;
      end
      $display("Filtered %0d samples (%0d bypassed) over %0d register settings; %0d results checked, %0d clipped.",
               samples_sent, bypassed_samples, settings_loaded, results_checked,
               clipped_results);
      $display("Traffic ran with sender-side gaps, receiver-side gaps and none, plus a long output stall.");
      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/biq_pkg.sv
hdl/biq_mul.sv
hdl/biq_coef.sv
hdl/biq_seq.sv
hdl/biquad_highpass_filter.sv
test/testbench.sv
